### hdl/stack_alu_executor_macros.svh
// ----------------------------------------------------------------------------
// stack alu executor assertion macros
// shared concurrent assertion forms for the executor blocks
// ----------------------------------------------------------------------------
`ifndef STACK_ALU_EXECUTOR_MACROS_SVH
`define STACK_ALU_EXECUTOR_MACROS_SVH

// same-cycle implication
`define SAE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sae_pkg.sv
// ----------------------------------------------------------------------------
// sae_pkg
// shared types, codes and constants of the stack alu executor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sae_pkg;

   localparam int DATA_W          = 32;
   localparam int OP_W            = 4;
   localparam int STATUS_W        = 2;
   localparam int DEPTH_OUT_W     = 7;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int ITER_W          = 5;
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);

   // word codes
   localparam logic [OP_W-1:0] OP_LIT   = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 4'd1;
   localparam logic [OP_W-1:0] OP_SUB   = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
   localparam logic [OP_W-1:0] OP_EQ    = 4'd5;
   localparam logic [OP_W-1:0] OP_DUP   = 4'd6;
   localparam logic [OP_W-1:0] OP_DROP  = 4'd7;
   localparam logic [OP_W-1:0] OP_SWAP  = 4'd8;
   localparam logic [OP_W-1:0] OP_PRINT = 4'd9;
   localparam logic [OP_W-1:0] OP_TEST  = 4'd10;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_A,
      S_LOAD_A,
      S_EXEC,
      S_SWAP,
      S_WAIT,
      S_RESP
   } seq_state_type;

   typedef enum logic [3:0] {
      A_IDLE,
      A_ADD,
      A_SUB,
      A_EQ,
      A_MUL,
      A_NEGA,
      A_NEGB,
      A_DIV,
      A_NEGQ,
      A_DONE
   } alu_state_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV,
      ALU_EQ
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

endpackage

`default_nettype wire

### hdl/sae_stack_mem.sv
// ----------------------------------------------------------------------------
// sae_stack_mem
// data stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sae_stack_mem #(
   parameter int  STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF,
   localparam int AddrW       = $clog2(STACK_DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AddrW-1:0]           wr_addr,
   input  wire logic [sae_pkg::DATA_W-1:0] wr_data,
   input  wire logic [AddrW-1:0]           rd_addr,
   output logic      [sae_pkg::DATA_W-1:0] rd_data
);

   logic [sae_pkg::DATA_W-1:0] mem [STACK_DEPTH];
   logic [sae_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/sae_alu.sv
// ----------------------------------------------------------------------------
// sae_alu
// iterative arithmetic unit around one shared 33-bit adder: add, sub, eq in
// one step, shift-add multiply and restoring signed divide one bit a step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sae_alu (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sae_pkg::alu_ctl_type       ctl,
   input  wire logic [sae_pkg::DATA_W-1:0] a,
   input  wire logic [sae_pkg::DATA_W-1:0] b,
   output logic                            done,
   output logic      [sae_pkg::DATA_W-1:0] result
);

   localparam int W = sae_pkg::DATA_W;

   sae_pkg::alu_state_type state_ff, state_in;
   logic [W-1:0]              acc_ff, acc_in;
   logic [W-1:0]              opa_ff, opa_in;
   logic [W-1:0]              opb_ff, opb_in;
   logic [sae_pkg::ITER_W-1:0] cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;

   logic [W-1:0] x;
   logic [W-1:0] y;
   logic         sub;
   logic [W:0]   sum;
   logic [W-1:0] rem_sh;
   logic         ge;

   // shared adder
   assign sum    = {1'b0, x} + ({1'b0, y} ^ {(W + 1){sub}}) + {{W{1'b0}}, sub};
   assign rem_sh = {acc_ff[W-2:0], opa_ff[W-1]};
   assign ge     = ~sum[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sae_pkg::A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      x        = acc_ff;
      y        = opb_ff;
      sub      = 1'b0;
      done     = 1'b0;
      case (state_ff)
         sae_pkg::A_IDLE: begin
            if (ctl.start) begin
               opa_in = a;
               opb_in = b;
               acc_in = '0;
               cnt_in = '0;
               neg_in = a[W-1] ^ b[W-1];
               case (ctl.op)
                  sae_pkg::ALU_ADD: state_in = sae_pkg::A_ADD;
                  sae_pkg::ALU_SUB: state_in = sae_pkg::A_SUB;
                  sae_pkg::ALU_EQ:  state_in = sae_pkg::A_EQ;
                  sae_pkg::ALU_MUL: state_in = sae_pkg::A_MUL;
                  sae_pkg::ALU_DIV: state_in = sae_pkg::A_NEGA;
                  default:          state_in = sae_pkg::A_IDLE;
               endcase
            end
         end
         sae_pkg::A_ADD: begin
            x        = opa_ff;
            acc_in   = sum[W-1:0];
            state_in = sae_pkg::A_DONE;
         end
         sae_pkg::A_SUB: begin
            x        = opa_ff;
            sub      = 1'b1;
            acc_in   = sum[W-1:0];
            state_in = sae_pkg::A_DONE;
         end
         sae_pkg::A_EQ: begin
            x        = opa_ff;
            sub      = 1'b1;
            acc_in   = (sum[W-1:0] == '0) ? W'(1) : '0;
            state_in = sae_pkg::A_DONE;
         end
         sae_pkg::A_MUL: begin
            if (opa_ff[0]) begin
               acc_in = sum[W-1:0];
            end
            opa_in = {1'b0, opa_ff[W-1:1]};
            opb_in = {opb_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sae_pkg::ITER_LAST) begin
               state_in = sae_pkg::A_DONE;
            end
         end
         sae_pkg::A_NEGA: begin
            x   = '0;
            y   = opa_ff;
            sub = 1'b1;
            if (opa_ff[W-1]) begin
               opa_in = sum[W-1:0];
            end
            state_in = sae_pkg::A_NEGB;
         end
         sae_pkg::A_NEGB: begin
            x   = '0;
            sub = 1'b1;
            if (opb_ff[W-1]) begin
               opb_in = sum[W-1:0];
            end
            state_in = sae_pkg::A_DIV;
         end
         sae_pkg::A_DIV: begin
            x      = rem_sh;
            sub    = 1'b1;
            acc_in = ge ? sum[W-1:0] : rem_sh;
            opa_in = {opa_ff[W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sae_pkg::ITER_LAST) begin
               state_in = sae_pkg::A_NEGQ;
            end
         end
         sae_pkg::A_NEGQ: begin
            x        = '0;
            y        = opa_ff;
            sub      = 1'b1;
            acc_in   = neg_ff ? sum[W-1:0] : opa_ff;
            state_in = sae_pkg::A_DONE;
         end
         sae_pkg::A_DONE: begin
            done     = 1'b1;
            state_in = sae_pkg::A_IDLE;
         end
         default: begin
            state_in = sae_pkg::A_IDLE;
         end
      endcase
   end

   assign result = acc_ff;

endmodule

`default_nettype wire

### hdl/stack_alu_executor.sv
// ----------------------------------------------------------------------------
// stack_alu_executor: forth-style data stack word executor
// steps: idle, read top, load second, execute, then a swap write or an alu wait
// for add/sub/eq/mul/div, then response; mul and div run 32-step alu iterations
// handshake: one request at a time, next accept in the cycle after the response is taken
// reset: synchronous, active high; empties the stack, contents stay unknown
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stack_alu_executor_macros.svh"

module stack_alu_executor #(
   parameter int STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic        [sae_pkg::OP_W-1:0]     req_opcode,
   input  wire logic signed [sae_pkg::DATA_W-1:0]   req_literal,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed      [sae_pkg::DATA_W-1:0]   rsp_value,
   output logic                                     rsp_value_valid,
   output logic             [sae_pkg::STATUS_W-1:0] rsp_status,
   output logic             [sae_pkg::DEPTH_OUT_W-1:0] rsp_depth
);

   localparam int W  = sae_pkg::DATA_W;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int DW = sae_pkg::DEPTH_OUT_W;

   sae_pkg::seq_state_type state_ff, state_in;
   logic [sae_pkg::OP_W-1:0]     op_ff, op_in;
   logic [W-1:0]                 lit_ff, lit_in;
   logic [W-1:0]                 a_ff, a_in;
   logic [W-1:0]                 b_ff, b_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [W-1:0]                 value_ff, value_in;
   logic                         vvalid_ff, vvalid_in;
   logic [sae_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [CW-1:0]    count_m1;
   logic [CW-1:0]    count_m2;
   logic [CW-1:0]    count_p1;
   logic [1:0]       need;
   logic             under;
   logic             over;
   logic [CW+DW-1:0] depth_ext;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [W-1:0]  wr_data;
   logic [AW-1:0] rd_addr;
   logic [W-1:0]  rd_data;

   sae_pkg::alu_ctl_type alu_ctl;
   logic                 alu_done;
   logic [W-1:0]         alu_result;

   sae_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sae_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (a_ff),
      .b      (b_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign count_p1 = count_ff + CW'(1);

   // operands needed on the stack
   always_comb begin
      case (op_ff)
         sae_pkg::OP_ADD, sae_pkg::OP_SUB, sae_pkg::OP_MUL, sae_pkg::OP_DIV,
         sae_pkg::OP_EQ, sae_pkg::OP_SWAP:                need = 2'd2;
         sae_pkg::OP_DUP, sae_pkg::OP_DROP, sae_pkg::OP_PRINT,
         sae_pkg::OP_TEST:                                need = 2'd1;
         default:                                         need = 2'd0;
      endcase
   end

   assign under = count_ff < {{(CW - 2){1'b0}}, need};
   assign over  = ((op_ff == sae_pkg::OP_LIT) || (op_ff == sae_pkg::OP_DUP)) &&
                  (count_ff == CW'(STACK_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sae_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      lit_ff    <= lit_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      value_ff  <= value_in;
      vvalid_ff <= vvalid_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      lit_in      = lit_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      count_in    = count_ff;
      value_in    = value_ff;
      vvalid_in   = vvalid_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[AW-1:0];
      wr_data     = b_ff;
      rd_addr     = count_m1[AW-1:0];
      alu_ctl.start = 1'b0;
      alu_ctl.op    = sae_pkg::ALU_ADD;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         sae_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               lit_in   = $unsigned(req_literal);
               state_in = sae_pkg::S_RD_A;
            end
         end
         sae_pkg::S_RD_A: begin
            b_in     = rd_data;
            rd_addr  = count_m2[AW-1:0];
            state_in = sae_pkg::S_LOAD_A;
         end
         sae_pkg::S_LOAD_A: begin
            a_in     = rd_data;
            state_in = sae_pkg::S_EXEC;
         end
         sae_pkg::S_EXEC: begin
            status_in = sae_pkg::ST_OK;
            value_in  = b_ff;
            vvalid_in = count_ff != '0;
            state_in  = sae_pkg::S_RESP;
            if (under) begin
               status_in = sae_pkg::ST_UNDER;
            end else if (over) begin
               status_in = sae_pkg::ST_OVER;
            end else if ((op_ff == sae_pkg::OP_DIV) && (b_ff == '0)) begin
               status_in = sae_pkg::ST_DIVZ;
            end else begin
               case (op_ff)
                  sae_pkg::OP_LIT: begin
                     wr_en     = 1'b1;
                     wr_data   = lit_ff;
                     count_in  = count_p1;
                     value_in  = lit_ff;
                     vvalid_in = 1'b1;
                  end
                  sae_pkg::OP_DUP: begin
                     wr_en     = 1'b1;
                     count_in  = count_p1;
                     vvalid_in = 1'b1;
                  end
                  sae_pkg::OP_DROP: begin
                     count_in  = count_m1;
                     value_in  = a_ff;
                     vvalid_in = count_m1 != '0;
                  end
                  sae_pkg::OP_SWAP: begin
                     wr_en    = 1'b1;
                     wr_addr  = count_m2[AW-1:0];
                     value_in = a_ff;
                     state_in = sae_pkg::S_SWAP;
                  end
                  sae_pkg::OP_PRINT, sae_pkg::OP_TEST: begin
                     count_in  = count_m1;
                     vvalid_in = 1'b1;
                  end
                  sae_pkg::OP_ADD: begin
                     alu_ctl.start = 1'b1;
                     alu_ctl.op    = sae_pkg::ALU_ADD;
                     state_in      = sae_pkg::S_WAIT;
                  end
                  sae_pkg::OP_SUB: begin
                     alu_ctl.start = 1'b1;
                     alu_ctl.op    = sae_pkg::ALU_SUB;
                     state_in      = sae_pkg::S_WAIT;
                  end
                  sae_pkg::OP_MUL: begin
                     alu_ctl.start = 1'b1;
                     alu_ctl.op    = sae_pkg::ALU_MUL;
                     state_in      = sae_pkg::S_WAIT;
                  end
                  sae_pkg::OP_DIV: begin
                     alu_ctl.start = 1'b1;
                     alu_ctl.op    = sae_pkg::ALU_DIV;
                     state_in      = sae_pkg::S_WAIT;
                  end
                  sae_pkg::OP_EQ: begin
                     alu_ctl.start = 1'b1;
                     alu_ctl.op    = sae_pkg::ALU_EQ;
                     state_in      = sae_pkg::S_WAIT;
                  end
                  default: begin
                     // undefined codes leave the stack alone
                     state_in = sae_pkg::S_RESP;
                  end
               endcase
            end
         end
         sae_pkg::S_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = count_m1[AW-1:0];
            wr_data  = a_ff;
            state_in = sae_pkg::S_RESP;
         end
         sae_pkg::S_WAIT: begin
            if (alu_done) begin
               wr_en     = 1'b1;
               wr_addr   = count_m2[AW-1:0];
               wr_data   = alu_result;
               count_in  = count_m1;
               value_in  = alu_result;
               vvalid_in = 1'b1;
               state_in  = sae_pkg::S_RESP;
            end
         end
         sae_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = sae_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sae_pkg::S_IDLE;
         end
      endcase
   end

   assign depth_ext       = {{DW{1'b0}}, count_ff};
   assign rsp_depth       = depth_ext[DW-1:0];
   assign rsp_value       = $signed(vvalid_ff ? value_ff : '0);
   assign rsp_value_valid = vvalid_ff;
   assign rsp_status      = status_ff;

   `SAE_ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(STACK_DEPTH), "stack count beyond depth")
   `SAE_ASSERT_IMPL(a_ready_excl_rsp, clock, reset, req_ready, !rsp_valid, "ready while response pending")
   `SAE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready right after request")
   `SAE_ASSERT_IMPL(a_alu_done_wait, clock, reset, alu_done, state_ff == sae_pkg::S_WAIT, "alu done outside wait")
   `SAE_ASSERT_NEXT(a_idle_after_rsp, clock, reset, rsp_valid && rsp_ready, req_ready, "not idle after response")

endmodule

`default_nettype wire

### tb/sv/stack_alu_executor_tb.sv
// ----------------------------------------------------------------------------
// stack_alu_executor_tb
// self-checking bench for the forth-style stack word executor: a short table
// of directed words, then random runs that climb to a full stack, drain it
// past empty and wander in between, all under several idle and stall
// patterns. responses are checked against typed table rows or an in-bench stack model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stack_alu_executor_tb;

   localparam int STACK_DEPTH      = sae_pkg::STACK_DEPTH_DEF;
   localparam int LIMIT_CYCLES     = 600000;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 60;
   localparam int ITEMS_PER_PHASE  = 381;
   localparam int NUM_DIRECTED     = 26;

   localparam logic [sae_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd11;
   localparam logic [sae_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic signed [sae_pkg::DATA_W-1:0]  value;
      logic                               value_valid;
      logic [sae_pkg::STATUS_W-1:0]       status;
      logic [sae_pkg::DEPTH_OUT_W-1:0]    depth;
   } word_result_type;

   typedef struct packed {
      logic [sae_pkg::OP_W-1:0]           op;
      logic [sae_pkg::DATA_W-1:0]         lit;
      logic                               typed;
      logic [sae_pkg::DATA_W-1:0]         value;
      logic                               value_valid;
      logic [sae_pkg::STATUS_W-1:0]       status;
      logic [sae_pkg::DEPTH_OUT_W-1:0]    depth;
   } stim_row_type;

   typedef enum logic [1:0] {
      GEN_BALANCED,
      GEN_CLIMB,
      GEN_DRAIN
   } gen_mode_type;

   localparam logic [sae_pkg::OP_W-1:0] POP_WORDS [9] = '{
      sae_pkg::OP_ADD, sae_pkg::OP_SUB, sae_pkg::OP_MUL, sae_pkg::OP_DIV,
      sae_pkg::OP_EQ, sae_pkg::OP_DROP, sae_pkg::OP_SWAP, sae_pkg::OP_PRINT,
      sae_pkg::OP_TEST
   };

   // rows with typed = 1 carry the expected response, the rest use the model
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      '{sae_pkg::OP_DROP,  32'h0,        1'b1, 32'h0,        1'b0, sae_pkg::ST_UNDER, 7'd0},
      '{sae_pkg::OP_ADD,   32'h0,        1'b1, 32'h0,        1'b0, sae_pkg::ST_UNDER, 7'd0},
      '{sae_pkg::OP_TEST,  32'hFFFFFFFF, 1'b1, 32'h0,        1'b0, sae_pkg::ST_UNDER, 7'd0},
      '{OP_UNUSED_HI,      32'h0,        1'b1, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_LIT,   32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b1, sae_pkg::ST_OK,    7'd1},
      '{sae_pkg::OP_SWAP,  32'h0,        1'b1, 32'h7FFFFFFF, 1'b1, sae_pkg::ST_UNDER, 7'd1},
      '{sae_pkg::OP_LIT,   32'h1,        1'b1, 32'h1,        1'b1, sae_pkg::ST_OK,    7'd2},
      '{sae_pkg::OP_ADD,   32'h0,        1'b1, 32'h80000000, 1'b1, sae_pkg::ST_OK,    7'd1},
      '{sae_pkg::OP_LIT,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1, sae_pkg::ST_OK,    7'd2},
      '{sae_pkg::OP_DIV,   32'h0,        1'b1, 32'h80000000, 1'b1, sae_pkg::ST_OK,    7'd1},
      '{sae_pkg::OP_LIT,   32'h0,        1'b1, 32'h0,        1'b1, sae_pkg::ST_OK,    7'd2},
      '{sae_pkg::OP_DIV,   32'h0,        1'b1, 32'h0,        1'b1, sae_pkg::ST_DIVZ,  7'd2},
      '{sae_pkg::OP_DROP,  32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_DUP,   32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_EQ,    32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_LIT,   32'hFFFFFFF9, 1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_LIT,   32'h2,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_DIV,   32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_LIT,   32'h3,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_SUB,   32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_SWAP,  32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_TEST,  32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_LIT,   32'h80000000, 1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_MUL,   32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{sae_pkg::OP_PRINT, 32'h0,        1'b0, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0},
      '{OP_UNUSED_LO,      32'h5A5A5A5A, 1'b1, 32'h0,        1'b0, sae_pkg::ST_OK,    7'd0}
   };

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic [sae_pkg::OP_W-1:0]              req_opcode;
   logic signed [sae_pkg::DATA_W-1:0]     req_literal;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [sae_pkg::DATA_W-1:0]     rsp_value;
   logic                                  rsp_value_valid;
   logic [sae_pkg::STATUS_W-1:0]          rsp_status;
   logic [sae_pkg::DEPTH_OUT_W-1:0]       rsp_depth;

   logic [sae_pkg::DATA_W-1:0]            stack_mem [STACK_DEPTH];
   int                                    stack_count;
   word_result_type                       expected_results [$];

   int                                    error_count;
   int                                    cycle_count;
   int                                    send_idle_pct;
   int                                    stall_pct;
   int                                    hold_trigger;
   int                                    hold_seen;
   int                                    hold_left;

   stack_alu_executor #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_literal(req_literal),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value),
      .rsp_value_valid(rsp_value_valid),
      .rsp_status(rsp_status),
      .rsp_depth(rsp_depth)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // stack model: applies one word and returns the response it gives
   function automatic word_result_type execute_word(
         input logic [sae_pkg::OP_W-1:0]   op,
         input logic [sae_pkg::DATA_W-1:0] lit);
      word_result_type            res;
      int                         n;
      int                         need;
      logic [sae_pkg::DATA_W-1:0] a;
      logic [sae_pkg::DATA_W-1:0] b;
      logic [sae_pkg::DATA_W-1:0] r;
      logic [sae_pkg::DATA_W-1:0] ma;
      logic [sae_pkg::DATA_W-1:0] mb;
      logic [sae_pkg::DATA_W-1:0] q;
      logic [sae_pkg::DATA_W-1:0] value;
      logic                       have_value;
      n = stack_count;
      a = '0;
      b = '0;
      r = '0;
      value = '0;
      have_value = 1'b0;
      res.status = sae_pkg::ST_OK;
      case (op)
         sae_pkg::OP_ADD, sae_pkg::OP_SUB, sae_pkg::OP_MUL, sae_pkg::OP_DIV,
         sae_pkg::OP_EQ, sae_pkg::OP_SWAP:                 need = 2;
         sae_pkg::OP_DUP, sae_pkg::OP_DROP, sae_pkg::OP_PRINT,
         sae_pkg::OP_TEST:                                 need = 1;
         default:                                          need = 0;
      endcase
      if (n < need) begin
         res.status = sae_pkg::ST_UNDER;
      end else if ((op == sae_pkg::OP_LIT || op == sae_pkg::OP_DUP) &&
                   n >= STACK_DEPTH) begin
         res.status = sae_pkg::ST_OVER;
      end else if (op == sae_pkg::OP_DIV && stack_mem[n-1] == '0) begin
         res.status = sae_pkg::ST_DIVZ;
      end else begin
         if (need == 2) begin
            a = stack_mem[n-2];
            b = stack_mem[n-1];
         end
         case (op)
            sae_pkg::OP_LIT: begin
               stack_mem[n] = lit;
               n++;
            end
            sae_pkg::OP_ADD: r = a + b;
            sae_pkg::OP_SUB: r = a - b;
            sae_pkg::OP_MUL: r = a * b;
            sae_pkg::OP_DIV: begin
               // truncating divide on magnitudes, sign fixed afterwards
               ma = a[sae_pkg::DATA_W-1] ? -a : a;
               mb = b[sae_pkg::DATA_W-1] ? -b : b;
               q  = ma / mb;
               r  = (a[sae_pkg::DATA_W-1] ^ b[sae_pkg::DATA_W-1]) ? -q : q;
            end
            sae_pkg::OP_EQ: r = (a == b) ? 32'd1 : 32'd0;
            sae_pkg::OP_DUP: begin
               stack_mem[n] = stack_mem[n-1];
               n++;
            end
            sae_pkg::OP_DROP: n--;
            sae_pkg::OP_SWAP: begin
               stack_mem[n-2] = b;
               stack_mem[n-1] = a;
            end
            sae_pkg::OP_PRINT, sae_pkg::OP_TEST: begin
               n--;
               value = stack_mem[n];
               have_value = 1'b1;
            end
            default: ;
         endcase
         if (op >= sae_pkg::OP_ADD && op <= sae_pkg::OP_EQ) begin
            stack_mem[n-2] = r;
            n--;
         end
      end
      stack_count = n;
      if (!have_value && n > 0) begin
         value = stack_mem[n-1];
         have_value = 1'b1;
      end
      res.value = value;
      res.value_valid = have_value;
      res.depth = n[sae_pkg::DEPTH_OUT_W-1:0];
      return res;
   endfunction

   function automatic logic [sae_pkg::DATA_W-1:0] rand_literal();
      case ($urandom_range(0, 6))
         0:       return 32'h0;
         1:       return 32'hFFFFFFFF;
         2:       return 32'h80000000;
         3:       return 32'h7FFFFFFF;
         4:       return 32'($urandom_range(0, 20)) - 32'd10;
         default: return $urandom;
      endcase
   endfunction

   // offer one request, then record its expected response once accepted
   task automatic send_word(input logic [sae_pkg::OP_W-1:0] op,
                            input logic [sae_pkg::DATA_W-1:0] lit,
                            input logic typed, input word_result_type typed_res);
      word_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_literal <= lit;
      do @(posedge clock); while (!req_ready);
      res = execute_word(op, lit);
      expected_results.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   task automatic wait_all_done();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic run_random(input int count);
      gen_mode_type              gen_mode;
      int                        mode_left;
      int                        sent;
      logic [sae_pkg::OP_W-1:0]  op;
      word_result_type           unused_res;
      gen_mode = GEN_BALANCED;
      mode_left = 0;
      unused_res = '0;
      for (sent = 0; sent < count; sent++) begin
         if (mode_left == 0) begin
            gen_mode = gen_mode_type'($urandom_range(GEN_BALANCED, GEN_DRAIN));
            case (gen_mode)
               GEN_CLIMB: mode_left = $urandom_range(100, 160);
               GEN_DRAIN: mode_left = $urandom_range(60, 120);
               default:   mode_left = $urandom_range(40, 150);
            endcase
         end
         mode_left--;
         if ($urandom_range(0, 99) < 5) begin
            op = sae_pkg::OP_W'($urandom_range(sae_pkg::OP_LIT, OP_UNUSED_HI));
         end else begin
            case (gen_mode)
               GEN_CLIMB: begin
                  if ($urandom_range(0, 99) < 70) op = sae_pkg::OP_LIT;
                  else if ($urandom_range(0, 99) < 50) op = sae_pkg::OP_DUP;
                  else op = sae_pkg::OP_W'($urandom_range(sae_pkg::OP_ADD,
                                                          sae_pkg::OP_TEST));
               end
               GEN_DRAIN: op = POP_WORDS[$urandom_range(0, 8)];
               default: begin
                  if (stack_count < 2 && $urandom_range(0, 99) < 80) op = sae_pkg::OP_LIT;
                  else if ($urandom_range(0, 99) < 35) op = sae_pkg::OP_LIT;
                  else op = sae_pkg::OP_W'($urandom_range(sae_pkg::OP_ADD,
                                                          sae_pkg::OP_TEST));
               end
            endcase
         end
         send_word(op, rand_literal(), 1'b0, unused_res);
      end
   endtask

   // receiver: random stalls plus one long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      word_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: response with no request outstanding: value %h status %0d",
                     $time, rsp_value, rsp_status);
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_value !== exp_res.value) begin
               error_count++;
               $display("%0t: value expected %h actual %h", $time, exp_res.value, rsp_value);
            end
            if (rsp_value_valid !== exp_res.value_valid) begin
               error_count++;
               $display("%0t: value_valid expected %b actual %b", $time,
                        exp_res.value_valid, rsp_value_valid);
            end
            if (rsp_status !== exp_res.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_res.status, rsp_status);
            end
            if (rsp_depth !== exp_res.depth) begin
               error_count++;
               $display("%0t: depth expected %0d actual %0d", $time,
                        exp_res.depth, rsp_depth);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      word_result_type typed_res;
      int              i;
      int              phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = sae_pkg::OP_LIT;
      req_literal = '0;
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_trigger = 0;
      hold_seen = 0;
      hold_left = 0;
      stack_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < NUM_DIRECTED; i++) begin
         typed_res.value = DIRECTED[i].value;
         typed_res.value_valid = DIRECTED[i].value_valid;
         typed_res.status = DIRECTED[i].status;
         typed_res.depth = DIRECTED[i].depth;
         send_word(DIRECTED[i].op, DIRECTED[i].lit, DIRECTED[i].typed, typed_res);
      end
      wait_all_done();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               // long hold-off so the block backs up onto the request side
               hold_trigger++;
            end
            1: begin
               send_idle_pct = 87;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 87;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct = 35;
            end
         endcase
         run_random(ITEMS_PER_PHASE);
         wait_all_done();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
